// ----- src/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W = 32;
    localparam int OP_W = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic exec;
    } dp_cmd_t;

endpackage

// ----- src/sorted_priority_queue_core.sv -----
// Top level of the sorted priority queue: stream ports, controller and datapath.
//
// Usage:
//   Input channel s_*: s_tuser carries the operation (push, pop head, clear),
//   s_tdata carries the signed 32-bit value used by push.
//   Output channel m_*: one result per accepted transfer with the head value
//   (zero when empty), the empty flag, the success flag and the entry count.
//   Entries stay sorted largest first; equal values leave last in, first out.
//   A push to a full queue or a pop on an empty queue leaves the queue as is
//   and reports failure; an unused operation code also reports failure.
// Timing:
//   A transfer is executed at the edge it is accepted; its result is valid on
//   the next cycle. One item is in flight at a time: a new transfer is not
//   accepted until its result has been taken. Insertion compares all entries
//   in parallel.
// Reset:
//   rst_n empties the queue and drops any pending result.
// Stall:
//   While m_tready is low a pending result holds and s_tready stays low.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_W-1:0]    s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]       s_tuser,   // [1:0] op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] head_value, [32] is_empty,
                                             // [33] done_ok, [38:34] entry_count
);

    dp_cmd_t                   cmd;
    logic signed [VALUE_W-1:0] head_value;
    logic                      is_empty;
    logic                      done_ok;
    logic [COUNT_OUT_W-1:0]    entry_count;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (s_tuser),
        .value       ($signed(s_tdata)),
        .head_value  (head_value),
        .is_empty    (is_empty),
        .done_ok     (done_ok),
        .entry_count (entry_count)
    );

    assign m_tdata = {1'b0, entry_count, done_ok, is_empty, head_value};

endmodule

// ----- src/spq_ctrl.sv -----
// Controller state machine: accept one transfer, then present its result.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd.exec  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.exec = in_valid;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/spq_datapath.sv -----
// Datapath: sorted row of entry cells, fill count and result fields.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    input  logic [OP_W-1:0]           op,
    input  logic signed [VALUE_W-1:0] value,
    output logic signed [VALUE_W-1:0] head_value,
    output logic                      is_empty,
    output logic                      done_ok,
    output logic [COUNT_OUT_W-1:0]    entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic signed [VALUE_W-1:0] cell_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] cell_next [CAPACITY];
    logic [CAPACITY-1:0]       gt;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      ok_reg;
    logic                      ok_next;
    logic                      full;
    logic                      empty;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);

    // compare every occupied cell against the pushed value at once
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            gt[k] = (CNT_W'(k) < count_reg) && (cell_reg[k] > value);
        end
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [VALUE_W-1:0] from_left;
        logic signed [VALUE_W-1:0] from_right;
        logic                      left_gt;

        if (k == 0)
        begin : g_first
            assign from_left = value;
            assign left_gt   = 1'b1;
        end
        else
        begin : g_rest
            assign from_left = cell_reg[k-1];
            assign left_gt   = gt[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign from_right = cell_reg[k];
        end
        else
        begin : g_inner
            assign from_right = cell_reg[k+1];
        end

        always_comb
        begin
            cell_next[k] = cell_reg[k];
            if (cmd.exec && op == OP_PUSH && !full)
            begin
                if (gt[k])
                begin
                    cell_next[k] = cell_reg[k];
                end
                else if (left_gt)
                begin
                    cell_next[k] = value;
                end
                else
                begin
                    cell_next[k] = from_left;
                end
            end
            else if (cmd.exec && op == OP_POP && !empty)
            begin
                cell_next[k] = from_right;
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[k] <= cell_next[k];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ok_next    = ok_reg;
        if (cmd.exec)
        begin
            ok_next = 1'b0;
            case (op)
                OP_PUSH:
                begin
                    if (!full)
                    begin
                        count_next = count_reg + CNT_ONE;
                        ok_next    = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (!empty)
                    begin
                        count_next = count_reg - CNT_ONE;
                        ok_next    = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                    ok_next    = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

    assign head_value  = empty ? '0 : cell_reg[0];
    assign is_empty    = empty;
    assign done_ok     = ok_reg;
    assign entry_count = COUNT_OUT_W'(count_reg);

endmodule

// ----- tb/sorted_priority_queue_core_tb.sv -----
// Self-checking testbench for the sorted priority queue core with random stream stalls.
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1550;
    localparam int CALM_ITEMS = 150;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0]   count;
        logic                     ok;
        logic                     empty;
        logic signed [VALUE_W-1:0] head;
    } queue_status_t;

    class queue_scoreboard;
        logic signed [VALUE_W-1:0] slots [CAPACITY];
        int            fill = 0;
        queue_status_t pending_status[$];
        int            mismatches = 0;
        int            checked = 0;
        int            full_refusals = 0;
        int            empty_pops = 0;
        int            peak_fill = 0;

        function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
            queue_status_t status;
            logic signed [VALUE_W-1:0] v;
            int pos;
            v = value;
            status.ok = 1'b0;
            case (op)
                OP_PUSH:
                begin
                    if (fill >= CAPACITY)
                    begin
                        full_refusals++;
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < fill && slots[pos] > v)
                            pos++;
                        for (int k = fill; k > pos; k--)
                            slots[k] = slots[k-1];
                        slots[pos] = v;
                        fill++;
                        status.ok = 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (fill == 0)
                    begin
                        empty_pops++;
                    end
                    else
                    begin
                        for (int k = 1; k < fill; k++)
                            slots[k-1] = slots[k];
                        fill--;
                        status.ok = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    fill = 0;
                    status.ok = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (fill > peak_fill)
                peak_fill = fill;
            status.head  = (fill > 0) ? slots[0] : '0;
            status.empty = (fill == 0);
            status.count = fill[COUNT_OUT_W-1:0];
            pending_status.push_back(status);
        endfunction

        function void check_response(logic [OUT_DATA_W-1:0] data);
            queue_status_t want;
            queue_status_t got;
            got = data[COUNT_OUT_W+VALUE_W+1:0];
            checked++;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result transfer, data %h", $realtime, data);
                return;
            end
            want = pending_status.pop_front();
            if (got.head !== want.head || got.empty !== want.empty ||
                got.ok !== want.ok || got.count !== want.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch head %0d/%0d empty %b/%b ok %b/%b count %0d/%0d",
                             $realtime, want.head, got.head, want.empty, got.empty,
                             want.ok, got.ok, want.count, got.count);
            end
        endfunction

        function int outstanding();
            return pending_status.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata;    // [31:0] value
    logic [OP_W-1:0]       s_tuser;    // [1:0] op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // [31:0] head_value, [32] is_empty,
                                       // [33] done_ok, [38:34] entry_count

    queue_scoreboard board = new;
    int  gap_pct;
    int  stall_pct;
    int  sent_items;

    sorted_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_response(m_tdata);
    end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(op, value);
        sent_items++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 7) - 4;
            1:       return {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'(0)} ^ $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random_phase(input int length);
        int push_pct;
        int roll;
        case ($urandom_range(0, 2))
            0:       push_pct = 80;
            1:       push_pct = 25;
            default: push_pct = 50;
        endcase
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        repeat (length)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send_request(OP_CLEAR, $urandom);
            else if (roll < 4)
                send_request(OP_NONE, $urandom);
            else if ($urandom_range(0, 99) < push_pct)
                send_request(OP_PUSH, pick_value());
            else
                send_request(OP_POP, $urandom);
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tuser    <= OP_NONE;
        s_tdata    <= '0;
        gap_pct    = 0;
        stall_pct  = 0;
        sent_items = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 30;
        stall_pct = 30;
        send_request(OP_POP, 32'hFFFF_FFFF);
        send_request(OP_CLEAR, 32'h0);
        send_request(OP_NONE, 32'h1234_5678);
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        for (int i = 0; i < CAPACITY - 4; i++)
            send_request(OP_PUSH, (i % 3 == 0) ? 32'h7FFF_FFFF : 32'(i - 6));
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_NONE, 32'hFFFF_FFFF);
        send_request(OP_POP, 32'h0);
        send_request(OP_CLEAR, 32'hFFFF_FFFF);

        while (sent_items < RANDOM_ITEMS - CALM_ITEMS)
            run_random_phase($urandom_range(20, 80));

        gap_pct   = 0;
        stall_pct = 0;
        repeat (CALM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       send_request(OP_CLEAR, $urandom);
                1:       send_request(OP_NONE, $urandom);
                2, 3, 4: send_request(OP_POP, $urandom);
                default: send_request(OP_PUSH, pick_value());
            endcase
        end
        s_tvalid <= 1'b0;

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Sent %0d transfers, checked %0d results, peak fill %0d of %0d",
                 sent_items, board.checked, board.peak_fill, CAPACITY);
        $display("Refused pushes on full queue: %0d, pops on empty queue: %0d, mismatches: %0d",
                 board.full_refusals, board.empty_pops, board.mismatches);
        if (board.mismatches == 0 && board.outstanding() == 0 && board.checked == sent_items)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
